[design/esd_pkg.sv]
package esd_pkg;

	localparam int unsigned EPOCH_W  = 32;
	localparam int unsigned YEAR_W   = 12;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned HOUR_W   = 5;
	localparam int unsigned MINUTE_W = 6;
	localparam int unsigned SECOND_W = 6;

	// Whole days since the epoch stay below 49711 for any 32-bit input.
	localparam int unsigned DAYS_W   = 16;
	localparam int unsigned YLEN_W   = 9;
	localparam int unsigned REM_W    = 6;
	// Each division takes two steps: form the product, then split it.
	localparam int unsigned STEP_W   = 1;

	localparam int unsigned OUT_BITS = YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W + SECOND_W;
	localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [REM_W:0]    SEC_PER_MIN   = 7'd60;
	localparam logic [REM_W:0]    HOUR_PER_DAY  = 7'd24;

	// Reciprocal constants: for any 32-bit n, n / 60 is (n * RECIP_60) >> SHIFT_60
	// and n / 3 is (n * RECIP_3) >> SHIFT_3. Division by 24 divides n >> 3 by 3.
	localparam logic [EPOCH_W-1:0] RECIP_60     = 32'h8888_8889;
	localparam int unsigned        SHIFT_60     = 37;
	localparam logic [EPOCH_W-1:0] RECIP_3      = 32'hAAAA_AAAB;
	localparam int unsigned        SHIFT_3      = 33;
	localparam int unsigned        PRE_SHIFT_24 = 3;

	localparam logic [YEAR_W-1:0] YEAR_BASE     = 12'd1970;
	// Only century year the calendar can reach that is a common year.
	localparam logic [YEAR_W-1:0] YEAR_CENTURY  = 12'd2100;
	localparam logic [YLEN_W-1:0] DAYS_COMMON   = 9'd365;
	localparam logic [YLEN_W-1:0] DAYS_LEAP     = 9'd366;
	localparam logic [DAY_W-1:0]  FEB_LEAP_DAYS = 5'd29;
	localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_LAST   = 4'd11;

	localparam logic [DAY_W-1:0] MONTH_DAYS [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef enum logic [1:0] {
		TGT_SEC,
		TGT_MIN,
		TGT_HOUR
	} div_tgt_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_SEC,
		ST_DIV_MIN,
		ST_DIV_HOUR,
		ST_YEAR,
		ST_MONTH,
		ST_DONE
	} esd_state_t;

	typedef struct packed {
		logic     load;
		logic     div_step;
		logic     div_last;
		div_tgt_t tgt;
		logic     yr_step;
		logic     mo_step;
		logic     out_load;
	} esd_cmd_t;

	typedef struct packed {
		logic year_fit;
		logic month_fit;
		logic out_free;
	} esd_stat_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mo,
			input logic leap);
		logic [DAY_W-1:0] len;
		if (mo > MONTH_LAST) begin
			len = MONTH_DAYS[0];
		end else begin
			len = MONTH_DAYS[mo];
		end
		if (mo == MONTH_FEB && leap) begin
			len = FEB_LEAP_DAYS;
		end
		return len;
	endfunction

endpackage

[design/esd_datapath.sv]
module esd_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  esd_pkg::esd_cmd_t                  cmd,
	output esd_pkg::esd_stat_t                 stat,
	input  logic [esd_pkg::EPOCH_W-1:0]        epoch_seconds,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic [esd_pkg::OUT_W-1:0]          out_data
);

	logic [esd_pkg::EPOCH_W-1:0]   work_q;
	logic [2*esd_pkg::EPOCH_W-1:0] prod_q;
	logic [esd_pkg::SECOND_W-1:0]  sec_q;
	logic [esd_pkg::MINUTE_W-1:0]  min_q;
	logic [esd_pkg::HOUR_W-1:0]    hour_q;
	logic [esd_pkg::DAYS_W-1:0]    days_q;
	logic [esd_pkg::YEAR_W-1:0]    year_q;
	logic [esd_pkg::MONTH_W-1:0]   mon_q;
	logic                          out_valid_q;
	logic [esd_pkg::OUT_W-1:0]     out_data_q;

	logic                          by_hour;
	logic [esd_pkg::REM_W:0]       divisor;
	logic [esd_pkg::EPOCH_W-1:0]   mul_a;
	logic [esd_pkg::EPOCH_W-1:0]   mul_b;
	logic [2*esd_pkg::EPOCH_W-1:0] prod;
	logic [2*esd_pkg::EPOCH_W-1:0] quot_wide;
	logic [esd_pkg::EPOCH_W-1:0]   quot;
	logic [esd_pkg::EPOCH_W-1:0]   back;
	logic [esd_pkg::EPOCH_W-1:0]   rem_wide;
	logic [esd_pkg::REM_W-1:0]     rem_next;
	logic                          leap;
	logic [esd_pkg::YLEN_W-1:0]    ylen;
	logic [esd_pkg::DAY_W-1:0]     mlen;

	// Division by a small constant as a reciprocal multiplication. The first
	// step registers the 32 by 32 product, the second takes the quotient from
	// its upper bits and the remainder by multiplying back.
	assign by_hour   = (cmd.tgt == esd_pkg::TGT_HOUR);
	assign divisor   = by_hour ? esd_pkg::HOUR_PER_DAY : esd_pkg::SEC_PER_MIN;
	assign mul_a     = by_hour ? (work_q >> esd_pkg::PRE_SHIFT_24) : work_q;
	assign mul_b     = by_hour ? esd_pkg::RECIP_3 : esd_pkg::RECIP_60;
	assign prod      = {{esd_pkg::EPOCH_W{1'b0}}, mul_a} * {{esd_pkg::EPOCH_W{1'b0}}, mul_b};
	assign quot_wide = by_hour ? (prod_q >> esd_pkg::SHIFT_3) : (prod_q >> esd_pkg::SHIFT_60);
	assign quot      = quot_wide[esd_pkg::EPOCH_W-1:0];
	assign back      = quot * {{(esd_pkg::EPOCH_W-esd_pkg::REM_W-1){1'b0}}, divisor};
	assign rem_wide  = work_q - back;
	assign rem_next  = rem_wide[esd_pkg::REM_W-1:0];

	// Years reachable here run 1970 to 2106; 2100 is the only century year
	// among them that is not a leap year.
	assign leap = (year_q[1:0] == 2'd0) && (year_q != esd_pkg::YEAR_CENTURY);
	assign ylen = leap ? esd_pkg::DAYS_LEAP : esd_pkg::DAYS_COMMON;
	assign mlen = esd_pkg::month_len(mon_q, leap);

	assign stat.year_fit  = (days_q < {{(esd_pkg::DAYS_W-esd_pkg::YLEN_W){1'b0}}, ylen});
	assign stat.month_fit = (mon_q == esd_pkg::MONTH_LAST) ||
	                        (days_q < {{(esd_pkg::DAYS_W-esd_pkg::DAY_W){1'b0}}, mlen});
	assign stat.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			work_q <= epoch_seconds;
		end else if (cmd.div_step) begin
			if (cmd.div_last) begin
				work_q <= quot;
				unique case (cmd.tgt)
					esd_pkg::TGT_SEC:  sec_q <= rem_next;
					esd_pkg::TGT_MIN:  min_q <= rem_next;
					esd_pkg::TGT_HOUR: begin
						hour_q <= rem_next[esd_pkg::HOUR_W-1:0];
						days_q <= quot[esd_pkg::DAYS_W-1:0];
						year_q <= esd_pkg::YEAR_BASE;
						mon_q  <= '0;
					end
					default: ;
				endcase
			end else begin
				prod_q <= prod;
			end
		end
		if (cmd.yr_step) begin
			days_q <= days_q - {{(esd_pkg::DAYS_W-esd_pkg::YLEN_W){1'b0}}, ylen};
			year_q <= year_q + 1'b1;
		end
		if (cmd.mo_step) begin
			days_q <= days_q - {{(esd_pkg::DAYS_W-esd_pkg::DAY_W){1'b0}}, mlen};
			mon_q  <= mon_q + 1'b1;
		end
		if (cmd.out_load) begin
			out_data_q <= {{(esd_pkg::OUT_W-esd_pkg::OUT_BITS){1'b0}},
			               sec_q, min_q, hour_q,
			               days_q[esd_pkg::DAY_W-1:0] + 1'b1,
			               mon_q + 1'b1,
			               year_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

[design/esd_ctrl.sv]
module esd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  esd_pkg::esd_stat_t stat,
	output esd_pkg::esd_cmd_t  cmd
);

	esd_pkg::esd_state_t         state_q;
	esd_pkg::esd_state_t         state_next;
	logic [esd_pkg::STEP_W-1:0]  step_q;
	logic                        last_step;
	logic                        dividing;

	assign last_step = (step_q == {esd_pkg::STEP_W{1'b1}});
	assign dividing  = (state_q == esd_pkg::ST_DIV_SEC) ||
	                   (state_q == esd_pkg::ST_DIV_MIN) ||
	                   (state_q == esd_pkg::ST_DIV_HOUR);

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			esd_pkg::ST_IDLE:     if (in_valid) state_next = esd_pkg::ST_DIV_SEC;
			esd_pkg::ST_DIV_SEC:  if (last_step) state_next = esd_pkg::ST_DIV_MIN;
			esd_pkg::ST_DIV_MIN:  if (last_step) state_next = esd_pkg::ST_DIV_HOUR;
			esd_pkg::ST_DIV_HOUR: if (last_step) state_next = esd_pkg::ST_YEAR;
			esd_pkg::ST_YEAR:     if (stat.year_fit) state_next = esd_pkg::ST_MONTH;
			esd_pkg::ST_MONTH:    if (stat.month_fit) state_next = esd_pkg::ST_DONE;
			esd_pkg::ST_DONE:     if (stat.out_free) state_next = esd_pkg::ST_IDLE;
			default:              state_next = esd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.tgt      = esd_pkg::TGT_SEC;
		in_ready     = 1'b0;
		unique case (state_q)
			esd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			esd_pkg::ST_DIV_SEC: begin
				cmd.div_step = 1'b1;
				cmd.div_last = last_step;
			end
			esd_pkg::ST_DIV_MIN: begin
				cmd.div_step = 1'b1;
				cmd.div_last = last_step;
				cmd.tgt      = esd_pkg::TGT_MIN;
			end
			esd_pkg::ST_DIV_HOUR: begin
				cmd.div_step = 1'b1;
				cmd.div_last = last_step;
				cmd.tgt      = esd_pkg::TGT_HOUR;
			end
			esd_pkg::ST_YEAR:  cmd.yr_step  = !stat.year_fit;
			esd_pkg::ST_MONTH: cmd.mo_step  = !stat.month_fit;
			esd_pkg::ST_DONE:  cmd.out_load = stat.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= esd_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_next;
			if (dividing) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

endmodule

[design/epoch_seconds_to_datetime_top.sv]
// Converts an unsigned count of seconds since 1970-01-01 00:00:00 UTC into a
// Gregorian date and time of day, with the full leap-year rule.
// Input channel s_*: one word per conversion, tdata carries epoch_seconds.
// Output channel m_*: one word per input word, tdata carries year, month,
// day of month, hour, minute and second, packed from the lowest bit up.
// A conversion takes three constant divisions (by 60, 60 and 24), each a
// reciprocal multiplication that registers the product and then splits it.
// Then comes a walk over the years from 1970, a walk over the months of the
// year and a load of the output register; the year walk takes the largest
// share of a conversion. Only one word is in conversion at a time, so the
// next word can be taken in the cycle after the result is loaded.
// A finished result sits in an output register, so the next input word is
// taken as soon as the result has moved there, even while m_tready is low.
// If a second result is ready while the first is still stalled, the engine
// holds it until the output register is free. Reset clears the controller
// and the output valid flag; the controller idles ready, so s_tvalid must
// stay low while arst_n is low.
module epoch_seconds_to_datetime_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [esd_pkg::EPOCH_W-1:0] s_tdata,   // [31:0] epoch_seconds
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [11:0] year_value, [15:12] month_value, [20:16] day_of_month,
	// [25:21] hour_value, [31:26] minute_value, [37:32] second_value,
	// [39:38] zero
	output logic [esd_pkg::OUT_W-1:0]   m_tdata
);

	esd_pkg::esd_cmd_t  cmd;
	esd_pkg::esd_stat_t stat;

	// The controller sequences the divider, year walk and month walk.
	esd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the working registers and the output register.
	esd_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.epoch_seconds (s_tdata),
		.out_ready     (m_tready),
		.out_valid     (m_tvalid),
		.out_data      (m_tdata)
	);

endmodule

[design/esd_checker.sv]
module esd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [esd_pkg::OUT_W-1:0]   m_tdata
);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a conversion is running");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result word changed while stalled");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:12] >= 4'd1) && (m_tdata[15:12] <= 4'd12) &&
		             (m_tdata[20:16] >= 5'd1) && (m_tdata[11:0] >= 12'd1970) &&
		             (m_tdata[11:0] <= 12'd2106))
		else $error("date out of range");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[25:21] < 5'd24) && (m_tdata[31:26] < 6'd60) &&
		             (m_tdata[37:32] < 6'd60) && (m_tdata[39:38] == 2'd0))
		else $error("time of day out of range");

endmodule

bind epoch_seconds_to_datetime_top esd_checker u_esd_checker (.*);

[sim/testbench.sv]
// Self-checking bench for epoch_seconds_to_datetime_top.
// Epoch second counts go into the s_* stream. Each date word that comes back
// on m_* is checked field by field against its row's typed date, else a
// calendar predictor kept in this file. A short table of directed words runs
// first: the range ends, the century years 2000 and 2100, and the last and
// first second of years and months. Random words follow; half are plain and
// most of the rest sit at month starts, where the date walks can go wrong.
module testbench;

	// Field layout of one output word, lowest bits last in the list.
	typedef struct packed {
		logic [esd_pkg::OUT_W-esd_pkg::OUT_BITS-1:0] pad;
		logic [esd_pkg::SECOND_W-1:0]                second;
		logic [esd_pkg::MINUTE_W-1:0]                minute;
		logic [esd_pkg::HOUR_W-1:0]                  hour;
		logic [esd_pkg::DAY_W-1:0]                   day;
		logic [esd_pkg::MONTH_W-1:0]                 month;
		logic [esd_pkg::YEAR_W-1:0]                  year;
	} date_time_t;

	typedef struct {
		logic [esd_pkg::EPOCH_W-1:0] epoch;
		bit                          typed;
		date_time_t                  want;
	} stim_row_t;

	localparam int RANDOM_WORDS = 1730;
	localparam int LONG_HOLD    = 1500;
	localparam int DRAIN_CYCLES = 300;

	logic                        clk      = 1'b0;
	logic                        arst_n   = 1'b0;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [esd_pkg::EPOCH_W-1:0] s_tdata  = '0;
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	logic [esd_pkg::OUT_W-1:0]   m_tdata;

	date_time_t pending_dates[$];
	stim_row_t  stim_rows[$];
	int         mismatch_count = 0;
	bit         no_idle        = 1'b0;
	bit         hold_req       = 1'b0;

	epoch_seconds_to_datetime_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Calendar helpers. The month table is the usual common-year one and
	// February is patched for leap years.
	function automatic bit is_leap(input int unsigned yr);
		return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
	endfunction

	function automatic int unsigned year_length(input int unsigned yr);
		return is_leap(yr) ? 366 : 365;
	endfunction

	function automatic int unsigned month_length(input int unsigned mo, input int unsigned yr);
		int unsigned common_days[12];
		common_days = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		if (mo == 2 && is_leap(yr)) begin
			return 29;
		end
		return common_days[mo-1];
	endfunction

	// Expected date word for one epoch count: split off the time of day,
	// then walk whole years from 1970 and whole months within the year.
	function automatic date_time_t calendar_of(input logic [esd_pkg::EPOCH_W-1:0] epoch);
		date_time_t  r;
		int unsigned t;
		int unsigned f;
		int unsigned days;
		int unsigned yr;
		int unsigned mo;
		r        = '0;
		t        = epoch;
		f        = t % 60;
		r.second = f[esd_pkg::SECOND_W-1:0];
		t        = t / 60;
		f        = t % 60;
		r.minute = f[esd_pkg::MINUTE_W-1:0];
		t        = t / 60;
		f        = t % 24;
		r.hour   = f[esd_pkg::HOUR_W-1:0];
		days     = t / 24;
		yr       = 1970;
		while (days >= year_length(yr)) begin
			days = days - year_length(yr);
			yr++;
		end
		mo = 1;
		while (mo < 12 && days >= month_length(mo, yr)) begin
			days = days - month_length(mo, yr);
			mo++;
		end
		r.year  = yr[esd_pkg::YEAR_W-1:0];
		r.month = mo[esd_pkg::MONTH_W-1:0];
		f       = days + 1;
		r.day   = f[esd_pkg::DAY_W-1:0];
		return r;
	endfunction

	// Days from the epoch to the first day of the given month.
	function automatic longint days_to_month(input int unsigned yr, input int unsigned mo);
		longint d;
		d = 0;
		for (int unsigned y = 1970; y < yr; y++) begin
			d += year_length(y);
		end
		for (int unsigned m = 1; m < mo; m++) begin
			d += month_length(m, yr);
		end
		return d;
	endfunction

	// Random epoch count. Half are plain 32-bit values. The rest sit within
	// five seconds of a month start or in its first day, with extra weight on
	// the leap days near 2100, or near either end of the range. A month start
	// past the top of the range simply wraps, which is still a legal input.
	function automatic logic [esd_pkg::EPOCH_W-1:0] next_epoch();
		int unsigned kind;
		int unsigned yr;
		int unsigned mo;
		longint      secs;
		kind = $urandom_range(0, 9);
		if (kind <= 4) begin
			return $urandom;
		end
		if (kind <= 7) begin
			if (kind == 7) begin
				yr = $urandom_range(2096, 2104);
				mo = $urandom_range(2, 3);
			end else begin
				yr = $urandom_range(1970, 2106);
				mo = $urandom_range(1, 12);
			end
			secs = days_to_month(yr, mo) * 86400;
			if ($urandom_range(0, 3) == 0) begin
				secs += $urandom_range(0, 86399);
			end else begin
				secs += longint'($urandom_range(0, 10)) - 5;
			end
			return secs[esd_pkg::EPOCH_W-1:0];
		end
		if (kind == 8) begin
			return $urandom_range(0, 1 << 20);
		end
		return 32'hFFFF_FFFF - $urandom_range(0, 20_000_000);
	endfunction

	function automatic void add_row(input logic [esd_pkg::EPOCH_W-1:0] epoch, input bit typed,
			input int yr, input int mo, input int dy, input int hr, input int mi, input int sc);
		stim_row_t row;
		row.epoch       = epoch;
		row.typed       = typed;
		row.want        = '0;
		row.want.year   = yr[esd_pkg::YEAR_W-1:0];
		row.want.month  = mo[esd_pkg::MONTH_W-1:0];
		row.want.day    = dy[esd_pkg::DAY_W-1:0];
		row.want.hour   = hr[esd_pkg::HOUR_W-1:0];
		row.want.minute = mi[esd_pkg::MINUTE_W-1:0];
		row.want.second = sc[esd_pkg::SECOND_W-1:0];
		stim_rows.push_back(row);
	endfunction

	// Offers one word, after a random gap unless the current stretch runs
	// without idling, and records the expected date once it is accepted.
	// Ready is sampled at the edge before the nonblocking updates land, so
	// the exit condition is exactly the handshake of that edge.
	task automatic send_epoch(input logic [esd_pkg::EPOCH_W-1:0] epoch, input bit typed,
			input date_time_t want);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= epoch;
		do @(posedge clk); while (!s_tready);
		pending_dates.push_back(typed ? want : calendar_of(epoch));
	endtask

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic check_word(input date_time_t got);
		date_time_t want;
		if (pending_dates.size() == 0) begin
			$display("%0t: unexpected output word, expected none, actual %h", $time, got);
			mismatch_count++;
			return;
		end
		want = pending_dates.pop_front();
		compare_field("year", int'(want.year), int'(got.year));
		compare_field("month", int'(want.month), int'(got.month));
		compare_field("day", int'(want.day), int'(got.day));
		compare_field("hour", int'(want.hour), int'(got.hour));
		compare_field("minute", int'(want.minute), int'(got.minute));
		compare_field("second", int'(want.second), int'(got.second));
	endtask

	// Output side. Random stalls per word outside no-idle stretches, and a long
	// hold-off can be requested to back the block up until it refuses input.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			stall = no_idle ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			check_word(m_tdata);
		end
	end

	// Input side and the overall sequence of the run.
	initial begin
		date_time_t no_want;
		no_want = '0;

		// Typed rows: the range ends and the two century leap-day cases.
		add_row(32'd0,          1'b1, 1970, 1, 1, 0, 0, 0);
		add_row(32'hFFFF_FFFF,  1'b1, 2106, 2, 7, 6, 28, 15);
		add_row(32'd951782400,  1'b1, 2000, 2, 29, 0, 0, 0);
		add_row(32'd4107542400, 1'b1, 2100, 3, 1, 0, 0, 0);
		// Rows left to the predictor: minute, hour, day and year rollovers,
		// the leap days of 1972 and 2000, the end of common year 2099 and
		// of February 2100, the 31-bit boundary and alternating bit patterns.
		add_row(32'd1,          1'b0, 0, 0, 0, 0, 0, 0);
		add_row(32'd59,         1'b0, 0, 0, 0, 0, 0, 0);
		add_row(32'd3599,       1'b0, 0, 0, 0, 0, 0, 0);
		add_row(32'd86399,      1'b0, 0, 0, 0, 0, 0, 0);
		add_row(32'd31535999,   1'b0, 0, 0, 0, 0, 0, 0);
		add_row(32'd31536000,   1'b0, 0, 0, 0, 0, 0, 0);
		add_row(32'd68169600,   1'b0, 0, 0, 0, 0, 0, 0);
		add_row(32'd951782399,  1'b0, 0, 0, 0, 0, 0, 0);
		add_row(32'd951868800,  1'b0, 0, 0, 0, 0, 0, 0);
		add_row(32'd978307199,  1'b0, 0, 0, 0, 0, 0, 0);
		add_row(32'd4102444799, 1'b0, 0, 0, 0, 0, 0, 0);
		add_row(32'd4107542399, 1'b0, 0, 0, 0, 0, 0, 0);
		add_row(32'h7FFF_FFFF,  1'b0, 0, 0, 0, 0, 0, 0);
		add_row(32'h8000_0000,  1'b0, 0, 0, 0, 0, 0, 0);
		add_row(32'hAAAA_AAAA,  1'b0, 0, 0, 0, 0, 0, 0);
		add_row(32'h5555_5555,  1'b0, 0, 0, 0, 0, 0, 0);
		add_row(32'hFFFF_FFFE,  1'b0, 0, 0, 0, 0, 0, 0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) begin
			send_epoch(stim_rows[i].epoch, stim_rows[i].typed, stim_rows[i].want);
		end

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			// Every fourth stretch of 200 words runs back to back on both sides.
			no_idle = ((i / 200) % 4) == 2;
			// Back up the output for a long time while input keeps coming.
			if (i == 300 || i == 1200) begin
				hold_req = 1'b1;
			end
			// Let the block drain completely once before carrying on; the
			// last word has been taken, so stop offering it meanwhile.
			if (i == 900) begin
				s_tvalid <= 1'b0;
				wait (pending_dates.size() == 0);
			end
			send_epoch(next_epoch(), 1'b0, no_want);
		end
		s_tvalid <= 1'b0;

		wait (pending_dates.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// The timeout allows about five times the slowest correct run, which is
	// about 1750 words plus the long holds.
	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
